// ===== hw/rtl/bpg_pkg.sv =====
`default_nettype none

package bpg_pkg;

	// Operand and accumulator widths of the fixed-point datapath.
	localparam int SAMPLE_BITS = 16;
	localparam int ACC_BITS    = 40;
	localparam int HALF_W      = ACC_BITS / 2;
	localparam int MUL_W       = HALF_W + 1;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int FIN_W       = 2 * ACC_BITS + 2;
	localparam int OUT_SHIFT   = 42;
	localparam int OUT_W       = 32;

	// Alignment of a partial product inside the wide final accumulator.
	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_HALF = 2'd1;
	localparam logic [1:0] SH_FULL = 2'd2;

	typedef struct packed {
		logic                          side;
		logic signed [SAMPLE_BITS-1:0] weight_re;
		logic signed [SAMPLE_BITS-1:0] weight_im;
		logic signed [SAMPLE_BITS-1:0] sig_re;
		logic signed [SAMPLE_BITS-1:0] sig_im;
		logic                          path_end;
	} term_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] gain_re;
		logic signed [OUT_W-1:0] gain_im;
		logic                    saturated;
	} result_t;

	// Control that travels with one partial product of the final multiply.
	typedef struct packed {
		logic       vld;
		logic       load;
		logic       neg;
		logic [1:0] shift;
		logic       last;
		logic       im;
	} fin_op_t;

	// One rounded and clipped part of the gain.
	typedef struct packed {
		logic                    vld;
		logic                    im;
		logic signed [OUT_W-1:0] val;
		logic                    sat;
	} rnd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpg_mul.sv =====
`default_nettype none

module bpg_mul (
	input  wire logic                              clk,
	input  wire logic signed [bpg_pkg::MUL_W-1:0]  a,
	input  wire logic signed [bpg_pkg::MUL_W-1:0]  b,
	output logic signed [bpg_pkg::PROD_W-1:0]      p_s1
);

	// Shared signed multiplier with a registered product.
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bpg_fin.sv =====
`default_nettype none

module bpg_fin (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire bpg_pkg::fin_op_t                    op_s1,
	input  wire logic signed [bpg_pkg::PROD_W-1:0]   p_s1,
	output bpg_pkg::rnd_t                            rnd
);

	localparam int FW = bpg_pkg::FIN_W;
	localparam int SW = FW - bpg_pkg::OUT_SHIFT;

	logic signed [FW-1:0] acc_q;
	logic signed [FW-1:0] ext;
	logic signed [FW-1:0] addend;
	logic signed [FW-1:0] base;
	logic signed [FW-1:0] rounded;
	logic signed [SW-1:0] shifted;
	logic                 rnd_pend_q;
	logic                 rnd_im_q;
	logic                 clip;

	always_comb begin
		ext = {{(FW - bpg_pkg::PROD_W){p_s1[bpg_pkg::PROD_W-1]}}, p_s1};
		case (op_s1.shift)
			bpg_pkg::SH_HALF: addend = ext <<< bpg_pkg::HALF_W;
			bpg_pkg::SH_FULL: addend = ext <<< (2 * bpg_pkg::HALF_W);
			default:          addend = ext;
		endcase
		base = op_s1.load ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (op_s1.vld) begin
			acc_q <= op_s1.neg ? base - addend : base + addend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_pend_q <= 1'b0;
			rnd_im_q   <= 1'b0;
		end else begin
			rnd_pend_q <= op_s1.vld && op_s1.last;
			if (op_s1.vld && op_s1.last) begin
				rnd_im_q <= op_s1.im;
			end
		end
	end

	// Round half up at bit OUT_SHIFT, then clip to the signed output range.
	always_comb begin
		rounded = acc_q + (FW'(1) <<< (bpg_pkg::OUT_SHIFT - 1));
		shifted = rounded[FW-1:bpg_pkg::OUT_SHIFT];
		clip    = !((&shifted[SW-1:bpg_pkg::OUT_W-1]) || !(|shifted[SW-1:bpg_pkg::OUT_W-1]));
		rnd.vld = rnd_pend_q;
		rnd.im  = rnd_im_q;
		rnd.sat = clip;
		if (clip) begin
			rnd.val = shifted[SW-1] ? {1'b1, {(bpg_pkg::OUT_W-1){1'b0}}}
			                        : {1'b0, {(bpg_pkg::OUT_W-1){1'b1}}};
		end else begin
			rnd.val = shifted[bpg_pkg::OUT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/beam_path_gain_unit.sv =====
`default_nettype none

// Channel | Valid      | Ready      | Payload                 | Moves
// term    | term_valid | term_ready | term (bpg_pkg::term_t)  | one antenna term in
// res     | res_valid  | res_ready  | res (bpg_pkg::result_t) | one path gain out
//
// A term passes the accept cycle, then the shared multiplier forms its four real products in turn.
// A receive term marked path_end goes on after its four term products: it settles the sums in
// S_WAIT (waiting there while the previous gain is untaken), forms the sixteen partial products
// of the final 40 by 40 bit complex multiply, and finishes and rounds in S_DRAIN.
// Reset clears the sequencer, the four term accumulators and the result valid flag.
// A result waiting on res_ready does not stop later terms; only the next path end waits.

module beam_path_gain_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             term_valid,
	output logic                  term_ready,
	input  wire bpg_pkg::term_t   term,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output bpg_pkg::result_t      res
);

	localparam int AW = bpg_pkg::ACC_BITS;
	localparam int HW = bpg_pkg::HALF_W;
	localparam int MW = bpg_pkg::MUL_W;

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TERM  = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;

	// Control that travels with one term product.
	typedef struct packed {
		logic vld;
		logic side;
		logic im;
		logic neg;
	} term_op_t;

	logic [2:0]           state_q;
	logic [3:0]           step_q;
	bpg_pkg::term_t       item_q;
	logic signed [AW-1:0] tx_re_q;
	logic signed [AW-1:0] tx_im_q;
	logic signed [AW-1:0] rx_re_q;
	logic signed [AW-1:0] rx_im_q;
	logic                 res_valid_q;
	bpg_pkg::result_t     res_q;

	logic signed [MW-1:0]              mul_a;
	logic signed [MW-1:0]              mul_b;
	logic signed [bpg_pkg::PROD_W-1:0] p_s1;
	term_op_t                          term_op;
	term_op_t                          term_op_s1;
	bpg_pkg::fin_op_t                  fin_op;
	bpg_pkg::fin_op_t                  fin_op_s1;
	bpg_pkg::rnd_t                     rnd;

	logic [1:0]           sub;
	logic [1:0]           quad;
	logic signed [AW-1:0] opx;
	logic signed [AW-1:0] opy;
	logic signed [AW-1:0] cur;
	logic signed [AW-1:0] nxt;
	logic signed [AW-1:0] term_add;

	assign term_ready = (state_q == S_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	assign sub  = step_q[1:0];
	assign quad = step_q[3:2];

	// Operand selection for the shared multiplier. During a term the step picks one of
	// the four real products. During the final multiply the upper two step bits pick
	// which complex cross product is formed and the lower two pick the partial product
	// of the split 40 bit operands: a signed upper half and an unsigned lower half.
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		term_op = '0;
		fin_op  = '0;
		opx     = quad[0] ? tx_im_q : tx_re_q;
		opy     = (quad[0] ^ quad[1]) ? rx_im_q : rx_re_q;
		unique case (state_q)
			S_TERM: begin
				mul_a = sub[0] ? MW'(item_q.weight_im) : MW'(item_q.weight_re);
				mul_b = (sub[0] ^ sub[1]) ? MW'(item_q.sig_im) : MW'(item_q.sig_re);
				term_op.vld  = 1'b1;
				term_op.side = item_q.side;
				term_op.im   = sub[1];
				term_op.neg  = (sub == 2'd1);
			end
			S_FIN: begin
				mul_a = sub[1] ? {1'b0, opx[HW-1:0]} : {opx[AW-1], opx[AW-1:HW]};
				mul_b = sub[0] ? {1'b0, opy[HW-1:0]} : {opy[AW-1], opy[AW-1:HW]};
				fin_op.vld   = 1'b1;
				fin_op.load  = (sub == 2'd0) && !quad[0];
				fin_op.neg   = (quad == 2'd1);
				fin_op.last  = quad[0] && (sub == 2'd3);
				fin_op.im    = quad[1];
				if (sub == 2'd0) begin
					fin_op.shift = bpg_pkg::SH_FULL;
				end else if (sub == 2'd3) begin
					fin_op.shift = bpg_pkg::SH_NONE;
				end else begin
					fin_op.shift = bpg_pkg::SH_HALF;
				end
			end
			default: begin
			end
		endcase
	end

	bpg_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (p_s1)
	);

	bpg_fin u_fin (
		.clk    (clk),
		.arst_n (arst_n),
		.op_s1  (fin_op_s1),
		.p_s1   (p_s1),
		.rnd    (rnd)
	);

	// The operation tags follow their product through the multiplier register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_op_s1 <= '0;
			fin_op_s1  <= '0;
		end else begin
			term_op_s1 <= term_op;
			fin_op_s1  <= fin_op;
		end
	end

	// A term product is a 16 by 16 bit result and fits the accumulator, which wraps.
	assign term_add = p_s1[AW-1:0];

	always_comb begin
		case ({term_op_s1.side, term_op_s1.im})
			2'b00:   cur = tx_re_q;
			2'b01:   cur = tx_im_q;
			2'b10:   cur = rx_re_q;
			default: cur = rx_im_q;
		endcase
		nxt = term_op_s1.neg ? cur - term_add : cur + term_add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_re_q <= '0;
			tx_im_q <= '0;
			rx_re_q <= '0;
			rx_im_q <= '0;
		end else if (state_q == S_DRAIN && step_q[0]) begin
			tx_re_q <= '0;
			tx_im_q <= '0;
			rx_re_q <= '0;
			rx_im_q <= '0;
		end else if (term_op_s1.vld) begin
			case ({term_op_s1.side, term_op_s1.im})
				2'b00:   tx_re_q <= nxt;
				2'b01:   tx_im_q <= nxt;
				2'b10:   rx_re_q <= nxt;
				default: rx_im_q <= nxt;
			endcase
		end
	end

	// Sequencer. A path end waits in S_WAIT until the result register is free, so the
	// rounded parts can be written into it as they come out of the final unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (term_valid) begin
						state_q <= S_TERM;
						step_q  <= '0;
					end
				end
				S_TERM: begin
					if (sub == 2'd3) begin
						state_q <= (item_q.side && item_q.path_end) ? S_WAIT : S_IDLE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_WAIT: begin
					if (!res_valid_q) begin
						state_q <= S_FIN;
						step_q  <= '0;
					end
				end
				S_FIN: begin
					if (step_q == 4'd15) begin
						state_q <= S_DRAIN;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_DRAIN: begin
					if (step_q[0]) begin
						state_q <= S_IDLE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					step_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (term_valid && term_ready) begin
			item_q <= term;
		end
	end

	// Result register: the real part lands first, the imaginary part on the last
	// drain cycle, which is also when the transaction is offered.
	always_ff @(posedge clk) begin
		if (rnd.vld) begin
			if (rnd.im) begin
				res_q.gain_im   <= rnd.val;
				res_q.saturated <= res_q.saturated | rnd.sat;
			end else begin
				res_q.gain_re   <= rnd.val;
				res_q.saturated <= rnd.sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DRAIN && step_q[0]) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// A new result is raised only at the end of the drain.
	a_res_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_DRAIN)
		else $error("result raised outside the drain step");

	// All four sums are cleared when a result is raised.
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> (tx_re_q == '0) && (tx_im_q == '0) &&
		                       (rx_re_q == '0) && (rx_im_q == '0))
		else $error("accumulators not cleared with the result");

	// The final unit never writes a part while a previous result is still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rnd.vld |-> !res_valid_q)
		else $error("rounded part written over a pending result");

	// An accepted term starts the product sequence at its first step.
	a_term_start: assert property (@(posedge clk) disable iff (!arst_n)
		term_valid && term_ready |=> (state_q == S_TERM) && (step_q == 4'd0))
		else $error("accepted term did not start the sequence");

endmodule

`default_nettype wire
